// ===== sv/msnp_pkg.sv =====
package msnp_pkg;

  localparam int MAX_NODES_DEF = 1024;
  localparam int MAX_EDGES_DEF = 4096;

  localparam logic [1:0] MODE_KIND = 2'd0;
  localparam logic [1:0] MODE_EDGE = 2'd1;
  localparam logic [1:0] MODE_RUN  = 2'd2;

  localparam logic [1:0] KIND_TARGET = 2'd1;
  localparam logic [1:0] KIND_SOURCE = 2'd2;

  localparam logic [10:0] NODE_COUNT_RST = 11'd1024;

endpackage

// ===== sv/msnp_ram.sv =====
module msnp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== sv/multi_source_nearest_pair_top.sv =====
// Nearest source-to-target search over an undirected weighted graph.
// The input channel (in_valid/in_ready) takes one beat per command: a node
// kind write, an edge add, or a run of the full search. The edge add reads the
// kind memory for both endpoints and writes up to two directed entries into
// the edge memory.
// A run first writes the per-node state for nodes 1..n. Then, for each
// settled node and once more when no node is left, it scans all n node
// entries; after each settle it scans all stored edge entries. It ends
// with a target scan over nodes 1..n. The run time is set by these
// sequential passes over the node and edge memories.
// A run gives one result beat on out_valid/out_ready; other commands give none.
// The result waits in an output register, so the next command is taken while
// it is pending; a run that finishes while the previous result is still
// stalled waits until it is taken. cfg_we writes node_count at once.
// Reset clears the control state, the edge count and node_count to 1024;
// the memories need no clearing pass.
module multi_source_nearest_pair_top
  import msnp_pkg::*;
#(
  parameter int MAX_NODES = MAX_NODES_DEF,
  parameter int MAX_EDGES = MAX_EDGES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_mode,
  input  logic [10:0] in_node,
  input  logic [10:0] in_other_node,
  input  logic [30:0] in_weight,
  input  logic [1:0]  in_node_kind,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_found,
  output logic [10:0] out_target_node,
  output logic [10:0] out_source_node,
  output logic [40:0] out_distance,
  input  logic        cfg_we,
  input  logic [10:0] cfg_wdata
);

  localparam int NA    = $clog2(MAX_NODES + 1);
  localparam int SLOTS = 2 * MAX_EDGES;
  localparam int EA    = $clog2(SLOTS);
  localparam int FW    = $clog2(SLOTS + 1);
  localparam int DW    = 31 + NA;
  localparam int NWW   = 2 + NA + DW;
  localparam int EWW   = 2 * NA + 31;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_EK1   = 4'd1;
  localparam logic [3:0] S_EK2   = 4'd2;
  localparam logic [3:0] S_EW    = 4'd3;
  localparam logic [3:0] S_INIT  = 4'd4;
  localparam logic [3:0] S_INITW = 4'd5;
  localparam logic [3:0] S_SEL   = 4'd6;
  localparam logic [3:0] S_SELE  = 4'd7;
  localparam logic [3:0] S_MARK  = 4'd8;
  localparam logic [3:0] S_ERD   = 4'd9;
  localparam logic [3:0] S_EEV   = 4'd10;
  localparam logic [3:0] S_NEV   = 4'd11;
  localparam logic [3:0] S_FIN   = 4'd12;
  localparam logic [3:0] S_FINE  = 4'd13;
  localparam logic [3:0] S_DONE  = 4'd14;

  logic [3:0]     state_r;
  logic [10:0]    node_count_r;
  logic [FW-1:0]  fill_r;
  logic [NA-1:0]  n_r, i_r, x_r, y_r, v_r, ov_r, to_r, bt_r, bs_r;
  logic [30:0]    w_r, ew_r;
  logic [1:0]     kx_r, ky_r;
  logic [DW-1:0]  dv_r, bd_r;
  logic [EA-1:0]  e_r;

  logic            out_valid_r, out_found_r;
  logic [10:0]     out_target_r, out_source_r;
  logic [40:0]     out_distance_r;

  logic            kind_we;
  logic [NA-1:0]   kind_waddr, kind_raddr;
  logic [1:0]      kind_wdata, kind_rdata;
  logic            node_we;
  logic [NA-1:0]   node_waddr, node_raddr;
  logic [NWW-1:0]  node_wdata, node_rdata;
  logic            edge_we;
  logic [EA-1:0]   edge_waddr;
  logic [EWW-1:0]  edge_wdata, edge_rdata;

  logic            in_acc, x_ok, y_ok, room, last_node, last_edge, edge_hit;
  logic            res_load;
  logic [NA-1:0]   in_x, in_y, n_clip;
  logic            rd_reached, rd_settled;
  logic [NA-1:0]   rd_origin, ed_from, ed_to;
  logic [DW-1:0]   rd_dist, nd;
  logic [30:0]     ed_w;

  assign in_ready  = (state_r == S_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign x_ok      = (in_node != 11'd0) && (32'(in_node) <= MAX_NODES);
  assign y_ok      = (in_other_node != 11'd0) && (32'(in_other_node) <= MAX_NODES);
  assign in_x      = NA'(32'(in_node));
  assign in_y      = NA'(32'(in_other_node));
  assign n_clip    = (32'(node_count_r) > MAX_NODES) ? NA'(MAX_NODES)
                                                     : NA'(32'(node_count_r));
  assign room      = (32'(fill_r) < SLOTS);
  assign last_node = (i_r == n_r);
  assign last_edge = ((FW'(e_r) + FW'(1)) == fill_r);
  assign res_load  = (state_r == S_DONE) && (!out_valid_r || out_ready);

  assign rd_reached = node_rdata[NWW-1];
  assign rd_settled = node_rdata[NWW-2];
  assign rd_origin  = node_rdata[DW+NA-1:DW];
  assign rd_dist    = node_rdata[DW-1:0];
  assign ed_from    = edge_rdata[EWW-1:NA+31];
  assign ed_to      = edge_rdata[NA+30:31];
  assign ed_w       = edge_rdata[30:0];
  assign nd         = dv_r + DW'(ew_r);
  assign edge_hit   = (ed_from == v_r) && (ed_to != '0) && (ed_to <= n_r);

  always_comb begin
    kind_we    = 1'b0;
    kind_waddr = in_x;
    kind_wdata = in_node_kind;
    kind_raddr = i_r;
    node_we    = 1'b0;
    node_waddr = i_r;
    node_wdata = '0;
    node_raddr = i_r;
    edge_we    = 1'b0;
    edge_waddr = fill_r[EA-1:0];
    edge_wdata = {x_r, y_r, w_r};
    case (state_r)
      S_IDLE: begin
        kind_raddr = in_x;
        kind_we    = in_acc && (in_mode == MODE_KIND) && x_ok;
      end
      S_EK1: kind_raddr = y_r;
      S_EK2: edge_we = (kx_r != KIND_TARGET) && room;
      S_EW: begin
        edge_wdata = {y_r, x_r, w_r};
        edge_we    = (ky_r != KIND_TARGET) && room;
      end
      S_INITW: begin
        node_we    = 1'b1;
        node_wdata = (kind_rdata == KIND_SOURCE) ? {1'b1, 1'b0, i_r, DW'(0)} : '0;
      end
      S_MARK: begin
        node_we    = 1'b1;
        node_waddr = v_r;
        node_wdata = {1'b1, 1'b1, ov_r, dv_r};
      end
      S_EEV: node_raddr = ed_to;
      S_NEV: begin
        node_waddr = to_r;
        node_wdata = {1'b1, rd_settled, ov_r, nd};
        node_we    = !rd_reached || (nd < rd_dist);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      node_count_r <= NODE_COUNT_RST;
      fill_r       <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        node_count_r <= cfg_wdata;
      end
      if (res_load) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (edge_we) begin
        fill_r <= fill_r + FW'(1);
      end
      case (state_r)
        S_IDLE: begin
          if (in_acc && (in_mode == MODE_EDGE) && x_ok && y_ok) begin
            x_r     <= in_x;
            y_r     <= in_y;
            w_r     <= in_weight;
            state_r <= S_EK1;
          end else if (in_acc && (in_mode == MODE_RUN)) begin
            n_r     <= n_clip;
            i_r     <= NA'(1);
            bt_r    <= '0;
            bs_r    <= '0;
            bd_r    <= '0;
            state_r <= (n_clip == '0) ? S_DONE : S_INIT;
          end
        end
        S_EK1: begin
          kx_r    <= kind_rdata;
          state_r <= S_EK2;
        end
        S_EK2: begin
          ky_r    <= kind_rdata;
          state_r <= S_EW;
        end
        S_EW: state_r <= S_IDLE;
        S_INIT: state_r <= S_INITW;
        S_INITW: begin
          if (last_node) begin
            i_r     <= NA'(1);
            v_r     <= '0;
            state_r <= S_SEL;
          end else begin
            i_r     <= i_r + NA'(1);
            state_r <= S_INIT;
          end
        end
        S_SEL: state_r <= S_SELE;
        S_SELE: begin
          if (rd_reached && !rd_settled && ((v_r == '0) || (rd_dist < dv_r))) begin
            v_r  <= i_r;
            dv_r <= rd_dist;
            ov_r <= rd_origin;
          end
          if (last_node) begin
            i_r <= NA'(1);
            if ((v_r == '0) && !(rd_reached && !rd_settled)) begin
              state_r <= S_FIN;
            end else begin
              state_r <= S_MARK;
            end
          end else begin
            i_r     <= i_r + NA'(1);
            state_r <= S_SEL;
          end
        end
        S_MARK: begin
          e_r <= '0;
          if (fill_r == '0) begin
            v_r     <= '0;
            state_r <= S_SEL;
          end else begin
            state_r <= S_ERD;
          end
        end
        S_ERD: state_r <= S_EEV;
        S_EEV: begin
          to_r <= ed_to;
          ew_r <= ed_w;
          if (edge_hit) begin
            state_r <= S_NEV;
          end else if (last_edge) begin
            v_r     <= '0;
            state_r <= S_SEL;
          end else begin
            e_r     <= e_r + EA'(1);
            state_r <= S_ERD;
          end
        end
        S_NEV: begin
          if (last_edge) begin
            v_r     <= '0;
            state_r <= S_SEL;
          end else begin
            e_r     <= e_r + EA'(1);
            state_r <= S_ERD;
          end
        end
        S_FIN: state_r <= S_FINE;
        S_FINE: begin
          if ((kind_rdata == KIND_TARGET) && rd_reached &&
              ((bt_r == '0) || (rd_dist < bd_r))) begin
            bt_r <= i_r;
            bd_r <= rd_dist;
            bs_r <= rd_origin;
          end
          if (last_node) begin
            state_r <= S_DONE;
          end else begin
            i_r     <= i_r + NA'(1);
            state_r <= S_FIN;
          end
        end
        S_DONE: begin
          if (res_load) begin
            out_found_r    <= (bt_r != '0);
            out_target_r   <= 11'(bt_r);
            out_source_r   <= 11'(bs_r);
            out_distance_r <= 41'(bd_r);
            state_r        <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid       = out_valid_r;
  assign out_found       = out_found_r;
  assign out_target_node = out_target_r;
  assign out_source_node = out_source_r;
  assign out_distance    = out_distance_r;

  msnp_ram #(.WIDTH(2), .DEPTH(MAX_NODES + 1)) u_kind_ram (
    .clk   (clk),
    .we    (kind_we),
    .waddr (kind_waddr),
    .wdata (kind_wdata),
    .raddr (kind_raddr),
    .rdata (kind_rdata)
  );

  msnp_ram #(.WIDTH(NWW), .DEPTH(MAX_NODES + 1)) u_node_ram (
    .clk   (clk),
    .we    (node_we),
    .waddr (node_waddr),
    .wdata (node_wdata),
    .raddr (node_raddr),
    .rdata (node_rdata)
  );

  msnp_ram #(.WIDTH(EWW), .DEPTH(SLOTS)) u_edge_ram (
    .clk   (clk),
    .we    (edge_we),
    .waddr (edge_waddr),
    .wdata (edge_wdata),
    .raddr (e_r),
    .rdata (edge_rdata)
  );

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(fill_r) <= SLOTS) else $error("edge count beyond capacity");

  a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_DONE))
    else $error("result raised outside the done state");

  a_mark_has_node: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MARK) |-> (v_r != '0)) else $error("settling node zero");

  a_found_consistent: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE) && (bt_r == '0) |-> (bd_r == '0) && (bs_r == '0))
    else $error("not-found result carries data");

endmodule
